// File: rtl/core/two_waypoint_shortest_route_assert.svh
// assertion macros for the two-waypoint route block
// used by files that check their own logic; needs aclk and aresetn in scope
`ifndef TWO_WAYPOINT_SHORTEST_ROUTE_ASSERT_SVH
`define TWO_WAYPOINT_SHORTEST_ROUTE_ASSERT_SVH
`ifndef SYNTHESIS
`define TWR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("two_waypoint_shortest_route: assertion failed");
`define TWR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("two_waypoint_shortest_route: implication failed");
`else
`define TWR_ASSERT(lbl, prop)
`define TWR_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: rtl/core/tws_pkg.sv
// shared types and constants of the two-waypoint route block
// no dependencies
package tws_pkg;

    localparam int MAX_NODES   = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int CFG_W       = 5;
    localparam int WEIGHT_W    = 16;
    localparam int DIST_W      = 21;
    localparam int KEY_W       = DIST_W + 1;
    localparam int COST_W      = 22;
    localparam int TBL_DEPTH   = MAX_NODES * MAX_NODES;
    localparam int ROUTE_DEPTH = 1 + 3 * (MAX_NODES - 1);
    localparam int LEN_W       = $clog2(ROUTE_DEPTH + 1);
    localparam int RT_DEPTH    = 2 * (2 ** LEN_W);
    localparam int IN_W        = 40;
    localparam int OUT_W       = 32;

    localparam logic [CNT_W-1:0] NODES_CNT = CNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_A,
        ST_ADD_B,
        ST_BAD,
        ST_ORD_INIT,
        ST_LEG_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_LEG_END,
        ST_TRACE,
        ST_POP,
        ST_ORD_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic add_a;
        logic add_b;
        logic bad_ld;
        logic ord_init;
        logic leg_init;
        logic scan;
        logic scan_end;
        logic leg_end;
        logic trace;
        logic pop;
        logic ord_end;
        logic emit_ld;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    range_bad;
        logic    out_free;
        logic    scan_last;
        logic    round_last;
        logic    dst_reached;
        logic    parent_ok;
        logic    chain_empty;
        logic    leg_last;
        logic    ord_last;
        logic    emit_last;
    } sts_t;

endpackage

// File: rtl/core/two_waypoint_shortest_route.sv
// top level of the two-waypoint shortest route block
// depends on tws_pkg, tws_ctrl, tws_dpath (and tws_ram below it)
//
// Loads undirected roads into a 16 x 16 weight table (first weight for a pair
// wins, a clear item empties it) and, on a find item, costs the orderings
// start-x-y-end and start-y-x-end with one Dijkstra pass per leg, then streams
// the cheaper route node by node, each item carrying the total cost and an
// unreachable flag. Clear and add items give no result. In a find, each selection
// round walks all n active nodes through the one read port of the weight table,
// relaxing and searching the next minimum in the same sweep; then the route is
// read out node by node. The result waits in an output register, so the next
// item is taken once the last node is loaded.
module two_waypoint_shortest_route (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input item
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // node_a, node_b, travel_time, start_node, end_node, waypoint_x, waypoint_y
    input  logic [tws_pkg::IN_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                 s_tuser,
    // result item
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // route_node, total_cost, zero pad
    output logic [tws_pkg::OUT_W-1:0]  m_tdata,
    // unreachable
    output logic                       m_tuser,
    // last_node
    output logic                       m_tlast,
    // node_count register
    input  logic                       cfg_wr_en,
    input  logic [tws_pkg::CFG_W-1:0]  cfg_wr_data
);

    logic [tws_pkg::CFG_W-1:0] node_count_reg;
    logic [tws_pkg::CNT_W-1:0] node_total;
    tws_pkg::cmd_t             cmd;
    tws_pkg::sts_t             sts;

    // node count register, reset to a full table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= tws_pkg::CFG_W'(tws_pkg::MAX_NODES);
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // clamp into two .. max nodes
    always_comb begin
        if (node_count_reg > tws_pkg::CFG_W'(tws_pkg::MAX_NODES)) begin
            node_total = tws_pkg::NODES_CNT;
        end else if (node_count_reg < tws_pkg::CFG_W'(2)) begin
            node_total = tws_pkg::CNT_W'(2);
        end else begin
            node_total = tws_pkg::CNT_W'(node_count_reg);
        end
    end

    // sequencer
    tws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, search state, route buffers, output register
    tws_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .node_total (node_total),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: rtl/core/tws_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: rtl/core/tws_ctrl.sv
// sequencer of the two-waypoint route block
// depends on tws_pkg; drives tws_dpath through cmd_t, reads sts_t
module tws_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tws_pkg::sts_t   sts,
    output tws_pkg::cmd_t   cmd
);

    tws_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tws_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tws_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = tws_pkg::ST_DISPATCH;
            end
            tws_pkg::ST_DISPATCH: begin
                unique case (sts.act)
                    tws_pkg::ACT_ADD:  state_next = tws_pkg::ST_ADD_A;
                    tws_pkg::ACT_FIND: state_next = sts.range_bad ? tws_pkg::ST_BAD
                                                                  : tws_pkg::ST_ORD_INIT;
                    default:           state_next = tws_pkg::ST_IDLE;
                endcase
            end
            tws_pkg::ST_ADD_A:    state_next = tws_pkg::ST_ADD_B;
            tws_pkg::ST_ADD_B:    state_next = tws_pkg::ST_IDLE;
            tws_pkg::ST_BAD: begin
                if (sts.out_free) state_next = tws_pkg::ST_IDLE;
            end
            tws_pkg::ST_ORD_INIT: state_next = tws_pkg::ST_LEG_INIT;
            tws_pkg::ST_LEG_INIT: state_next = tws_pkg::ST_SCAN;
            tws_pkg::ST_SCAN: begin
                if (sts.scan_last) state_next = tws_pkg::ST_SCAN_END;
            end
            tws_pkg::ST_SCAN_END: begin
                state_next = sts.round_last ? tws_pkg::ST_LEG_END : tws_pkg::ST_SCAN;
            end
            tws_pkg::ST_LEG_END: begin
                state_next = sts.dst_reached ? tws_pkg::ST_TRACE : tws_pkg::ST_POP;
            end
            tws_pkg::ST_TRACE: begin
                if (!sts.parent_ok) state_next = tws_pkg::ST_POP;
            end
            tws_pkg::ST_POP: begin
                if (sts.chain_empty) begin
                    state_next = sts.leg_last ? tws_pkg::ST_ORD_END : tws_pkg::ST_LEG_INIT;
                end
            end
            tws_pkg::ST_ORD_END: begin
                state_next = sts.ord_last ? tws_pkg::ST_EMIT_RD : tws_pkg::ST_ORD_INIT;
            end
            tws_pkg::ST_EMIT_RD:  state_next = tws_pkg::ST_EMIT_LD;
            tws_pkg::ST_EMIT_LD: begin
                if (sts.out_free) begin
                    state_next = sts.emit_last ? tws_pkg::ST_IDLE : tws_pkg::ST_EMIT_RD;
                end
            end
            default:              state_next = tws_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            tws_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            tws_pkg::ST_DISPATCH: cmd.clear    = (sts.act == tws_pkg::ACT_CLEAR);
            tws_pkg::ST_ADD_A:    cmd.add_a    = 1'b1;
            tws_pkg::ST_ADD_B:    cmd.add_b    = 1'b1;
            tws_pkg::ST_BAD:      cmd.bad_ld   = sts.out_free;
            tws_pkg::ST_ORD_INIT: cmd.ord_init = 1'b1;
            tws_pkg::ST_LEG_INIT: cmd.leg_init = 1'b1;
            tws_pkg::ST_SCAN:     cmd.scan     = 1'b1;
            tws_pkg::ST_SCAN_END: cmd.scan_end = 1'b1;
            tws_pkg::ST_LEG_END:  cmd.leg_end  = 1'b1;
            tws_pkg::ST_TRACE:    cmd.trace    = 1'b1;
            tws_pkg::ST_POP:      cmd.pop      = 1'b1;
            tws_pkg::ST_ORD_END:  cmd.ord_end  = 1'b1;
            tws_pkg::ST_EMIT_RD:  cmd          = '0;
            tws_pkg::ST_EMIT_LD:  cmd.emit_ld  = sts.out_free;
            default:              cmd          = '0;
        endcase
    end

endmodule

// File: rtl/core/tws_dpath.sv
// datapath of the two-waypoint route block: road table, dijkstra work state,
// route buffers and output register; depends on tws_pkg, tws_ram and the assert header
`include "two_waypoint_shortest_route_assert.svh"

module tws_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tws_pkg::cmd_t               cmd,
    output tws_pkg::sts_t               sts,
    input  logic [tws_pkg::CNT_W-1:0]   node_total,
    input  logic [tws_pkg::IN_W-1:0]    s_tdata,
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tws_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int NW = tws_pkg::NODE_W;

    // captured item
    tws_pkg::action_t            act_reg;
    logic [NW-1:0]               a_reg, b_reg, s_reg, d_reg, x_reg, y_reg;
    logic [tws_pkg::WEIGHT_W-1:0] w_reg;

    // road table
    logic [tws_pkg::TBL_DEPTH-1:0] tbl_valid_reg;
    logic                          add_new_reg;
    logic                          tbl_we;
    logic [2*NW-1:0]               tbl_waddr;
    logic [tws_pkg::WEIGHT_W-1:0]  w_rdata;
    logic                          e_valid_reg;

    // dijkstra state
    logic [tws_pkg::DIST_W-1:0]  dist_reg [tws_pkg::MAX_NODES];
    logic [NW-1:0]               par_reg  [tws_pkg::MAX_NODES];
    logic [tws_pkg::MAX_NODES-1:0] reached_reg, done_reg, par_ok_reg;
    logic [NW-1:0]               v_reg, p_v_reg, round_reg, u_reg, arg_reg, arg_next;
    logic                        p_valid_reg, u_reached_reg;
    logic [tws_pkg::DIST_W-1:0]  du_reg, cand;
    logic [tws_pkg::KEY_W-1:0]   best_reg, best_next, cur_key, new_key;
    logic                        relax, take;
    logic [NW-1:0]               rd_idx;

    // leg and order bookkeeping
    logic [1:0]                  leg_reg;
    logic                        ord_reg;
    logic [NW-1:0]               src, dst, wp_p, wp_q;
    logic [NW-1:0]               j_reg;
    logic [tws_pkg::CNT_W-1:0]   k_reg;
    logic [NW-1:0]               chain_reg [tws_pkg::MAX_NODES];
    logic [tws_pkg::LEN_W-1:0]   len_reg, len_a_reg, len_sel_reg, i_reg;
    logic [tws_pkg::COST_W-1:0]  cost_reg, cost_a_reg, cost_sel_reg;
    logic                        ok_reg, ok_a_reg, sel_reg, unr_reg, pick_a;

    // route buffers
    logic                        rt_we;
    logic [tws_pkg::LEN_W:0]     rt_waddr, rt_raddr;
    logic [NW-1:0]               rt_wdata, rt_rdata;

    // output register
    logic                        m_tvalid_reg;
    logic [NW-1:0]               out_node_reg;
    logic [tws_pkg::COST_W-1:0]  out_cost_reg;
    logic                        out_unr_reg, out_last_reg;

    // leg endpoints
    always_comb begin
        wp_p = ord_reg ? y_reg : x_reg;
        wp_q = ord_reg ? x_reg : y_reg;
        unique case (leg_reg)
            2'd0:    begin src = s_reg; dst = wp_p;  end
            2'd1:    begin src = wp_p;  dst = wp_q;  end
            2'd2:    begin src = wp_q;  dst = d_reg; end
            default: begin src = s_reg; dst = d_reg; end
        endcase
    end

    // relax and minimum search on the item returning from the table
    always_comb begin
        rd_idx  = cmd.leg_end ? dst : p_v_reg;
        cur_key = reached_reg[rd_idx] ? {1'b0, dist_reg[rd_idx]} : '1;
        cand    = du_reg + {{(tws_pkg::DIST_W-tws_pkg::WEIGHT_W){1'b0}}, w_rdata};
        relax   = p_valid_reg && u_reached_reg && !done_reg[p_v_reg] && e_valid_reg &&
                  ({1'b0, cand} < cur_key);
        new_key = relax ? {1'b0, cand} : cur_key;
        take    = p_valid_reg && !done_reg[p_v_reg] && (new_key <= best_reg);
        best_next = take ? new_key : best_reg;
        arg_next  = take ? p_v_reg : arg_reg;
    end

    assign tbl_we    = (cmd.add_a && !tbl_valid_reg[{a_reg, b_reg}]) ||
                       (cmd.add_b && add_new_reg);
    assign tbl_waddr = cmd.add_b ? {b_reg, a_reg} : {a_reg, b_reg};

    tws_ram #(
        .WIDTH (tws_pkg::WEIGHT_W),
        .DEPTH (tws_pkg::TBL_DEPTH)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (w_reg),
        .raddr ({u_reg, v_reg}),
        .rdata (w_rdata)
    );

    assign rt_we    = cmd.ord_init || (cmd.pop && (k_reg != '0));
    assign rt_waddr = {ord_reg, cmd.ord_init ? tws_pkg::LEN_W'(0) : len_reg};
    assign rt_wdata = cmd.ord_init ? s_reg
                                   : chain_reg[NW'(k_reg - tws_pkg::CNT_W'(1))];
    assign rt_raddr = {sel_reg, i_reg};

    tws_ram #(
        .WIDTH (NW),
        .DEPTH (tws_pkg::RT_DEPTH)
    ) u_rt_ram (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (rt_raddr),
        .rdata (rt_rdata)
    );

    assign pick_a = ok_a_reg && (!ok_reg || (cost_a_reg < cost_reg));

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                tbl_valid_reg <= '0;
            end else if (cmd.add_a) begin
                tbl_valid_reg[{a_reg, b_reg}] <= 1'b1;
                tbl_valid_reg[{b_reg, a_reg}] <= 1'b1;
            end
            if (cmd.emit_ld || cmd.bad_ld) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= tws_pkg::action_t'(s_tuser);
            a_reg   <= s_tdata[3:0];
            b_reg   <= s_tdata[7:4];
            w_reg   <= s_tdata[23:8];
            s_reg   <= s_tdata[27:24];
            d_reg   <= s_tdata[31:28];
            x_reg   <= s_tdata[35:32];
            y_reg   <= s_tdata[39:36];
            ord_reg <= 1'b0;
        end
        if (cmd.add_a) add_new_reg <= !tbl_valid_reg[{a_reg, b_reg}];

        e_valid_reg <= tbl_valid_reg[{u_reg, v_reg}];
        p_v_reg     <= v_reg;
        p_valid_reg <= cmd.scan;

        if (cmd.leg_init) begin
            // only the source is reached and done at the start of a leg
            reached_reg      <= tws_pkg::MAX_NODES'(1) << src;
            done_reg         <= tws_pkg::MAX_NODES'(1) << src;
            par_ok_reg       <= '0;
            dist_reg[src]    <= '0;
            u_reg            <= src;
            du_reg           <= '0;
            u_reached_reg    <= 1'b1;
            best_reg         <= '1;
            round_reg        <= '0;
            v_reg            <= '0;
        end else begin
            if (relax) begin
                dist_reg[p_v_reg]    <= cand;
                reached_reg[p_v_reg] <= 1'b1;
                par_reg[p_v_reg]     <= u_reg;
                par_ok_reg[p_v_reg]  <= 1'b1;
            end
            if (cmd.scan) v_reg <= v_reg + NW'(1);
            if (cmd.scan_end) begin
                done_reg[arg_next] <= 1'b1;
                u_reg              <= arg_next;
                du_reg             <= best_next[tws_pkg::DIST_W-1:0];
                u_reached_reg      <= (best_next != '1);
                best_reg           <= '1;
                round_reg          <= round_reg + NW'(1);
                v_reg              <= '0;
            end else begin
                best_reg <= best_next;
            end
        end
        arg_reg <= arg_next;

        if (cmd.ord_init) begin
            len_reg  <= tws_pkg::LEN_W'(1);
            cost_reg <= '0;
            ok_reg   <= 1'b1;
            leg_reg  <= '0;
        end
        if (cmd.leg_end) begin
            if (reached_reg[dst]) begin
                cost_reg <= cost_reg +
                            {{(tws_pkg::COST_W-tws_pkg::DIST_W){1'b0}}, dist_reg[dst]};
            end else begin
                ok_reg <= 1'b0;
            end
            j_reg <= dst;
            k_reg <= '0;
        end
        if (cmd.trace && par_ok_reg[j_reg]) begin
            chain_reg[k_reg[NW-1:0]] <= j_reg;
            k_reg <= k_reg + tws_pkg::CNT_W'(1);
            j_reg <= par_reg[j_reg];
        end
        if (cmd.pop) begin
            if (k_reg != '0) begin
                len_reg <= len_reg + tws_pkg::LEN_W'(1);
                k_reg   <= k_reg - tws_pkg::CNT_W'(1);
            end else begin
                leg_reg <= leg_reg + 2'd1;
            end
        end
        if (cmd.ord_end) begin
            if (!ord_reg) begin
                cost_a_reg <= cost_reg;
                ok_a_reg   <= ok_reg;
                len_a_reg  <= len_reg;
                ord_reg    <= 1'b1;
            end else begin
                sel_reg      <= !pick_a;
                len_sel_reg  <= pick_a ? len_a_reg : len_reg;
                cost_sel_reg <= pick_a ? cost_a_reg : (ok_reg ? cost_reg : '0);
                unr_reg      <= pick_a ? 1'b0 : !ok_reg;
                i_reg        <= '0;
            end
        end

        if (cmd.emit_ld) begin
            out_node_reg <= rt_rdata;
            out_cost_reg <= cost_sel_reg;
            out_unr_reg  <= unr_reg;
            out_last_reg <= sts.emit_last;
            i_reg        <= i_reg + tws_pkg::LEN_W'(1);
        end else if (cmd.bad_ld) begin
            out_node_reg <= s_reg;
            out_cost_reg <= '0;
            out_unr_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        sts.act         = act_reg;
        sts.range_bad   = ({1'b0, s_reg} >= node_total) || ({1'b0, d_reg} >= node_total) ||
                          ({1'b0, x_reg} >= node_total) || ({1'b0, y_reg} >= node_total);
        sts.out_free    = !m_tvalid_reg || m_tready;
        sts.scan_last   = ({1'b0, v_reg} == node_total - tws_pkg::CNT_W'(1));
        sts.round_last  = ({1'b0, round_reg} == node_total - tws_pkg::CNT_W'(2));
        sts.dst_reached = reached_reg[dst];
        sts.parent_ok   = par_ok_reg[j_reg];
        sts.chain_empty = (k_reg == '0);
        sts.leg_last    = (leg_reg == 2'd2);
        sts.ord_last    = ord_reg;
        sts.emit_last   = (i_reg == len_sel_reg - tws_pkg::LEN_W'(1));
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tws_pkg::OUT_W-NW-tws_pkg::COST_W){1'b0}}, out_cost_reg, out_node_reg};
    assign m_tuser  = out_unr_reg;
    assign m_tlast  = out_last_reg;

    `TWR_ASSERT_IMP(a_load_free, cmd.emit_ld || cmd.bad_ld, !m_tvalid_reg || m_tready)
    `TWR_ASSERT(a_chain_bound, k_reg <= tws_pkg::NODES_CNT)
    `TWR_ASSERT_IMP(a_scan_u_done, p_valid_reg, done_reg[u_reg])

endmodule

// File: test/two_waypoint_shortest_route_test.sv
// self-checking testbench for the two-waypoint shortest route block
// depends on tws_pkg and two_waypoint_shortest_route; needs no files or arguments
module two_waypoint_shortest_route_test;

    localparam int          LIMIT_CYCLES = 4000000;
    localparam int unsigned DIST_NONE    = 32'hFFFF_FFFF;

    typedef struct {
        tws_pkg::action_t act;
        logic [3:0] a, b;
        logic [15:0] w;
        logic [3:0] s, d, x, y;
    } road_req_t;

    typedef struct {
        logic [3:0]  node;
        logic [21:0] cost;
        logic        unr;
        logic        last;
    } route_step_t;

    // directed row: request plus an optional typed-in single result
    typedef struct {
        road_req_t   req;
        bit          typed;
        route_step_t res;
    } directed_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [tws_pkg::IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [tws_pkg::OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;
    logic             cfg_wr_en = 1'b0;
    logic [tws_pkg::CFG_W-1:0] cfg_wr_data = '0;

    two_waypoint_shortest_route u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow of the block state
    logic [16:0]  road_tbl [16][16];
    logic [4:0]   node_cfg;
    route_step_t  route_expect [$];
    bit           failed = 1'b0;
    int           src_idle_pct;
    int           snk_idle_pct;
    int unsigned  cycle_cnt = 0;

    // scratch for one ordering
    logic [3:0]   plan_path [$];
    int unsigned  plan_cost;
    bit           plan_ok;

    function automatic int active_nodes();
        if (node_cfg > 16) return 16;
        if (node_cfg < 2) return 2;
        return int'(node_cfg);
    endfunction

    // one shortest-path pass, appends nodes after src
    task automatic cost_leg(input int n, input int src, input int dst);
        int unsigned leg_dist [16];
        bit          done [16];
        int          par [16];
        int unsigned best;
        int          u, j;
        int unsigned cand;
        logic [3:0]  chain [$];
        for (int v = 0; v < n; v++) begin
            leg_dist[v] = DIST_NONE;
            done[v] = 0;
            par[v]  = -1;
        end
        leg_dist[src] = 0;
        for (int r = 0; r + 1 < n; r++) begin
            best = DIST_NONE;
            u = 0;
            // <= lets ties fall to the highest index, unreached included
            for (int v = 0; v < n; v++) begin
                if (!done[v] && leg_dist[v] <= best) begin
                    best = leg_dist[v];
                    u = v;
                end
            end
            done[u] = 1;
            if (leg_dist[u] != DIST_NONE) begin
                for (int v = 0; v < n; v++) begin
                    if (!done[v] && road_tbl[u][v][16]) begin
                        cand = leg_dist[u] + road_tbl[u][v][15:0];
                        if (cand < leg_dist[v]) begin
                            leg_dist[v] = cand;
                            par[v] = u;
                        end
                    end
                end
            end
        end
        if (leg_dist[dst] == DIST_NONE) begin
            plan_ok = 0;
        end else begin
            plan_cost += leg_dist[dst];
            j = dst;
            while (chain.size() < 16 && par[j] >= 0) begin
                chain.push_front(4'(j));
                j = par[j];
            end
            foreach (chain[i]) plan_path.insert(plan_path.size(), chain[i]);
        end
    endtask

    task automatic plan_order(input int n, input int s, input int p, input int q, input int d);
        plan_path.delete();
        plan_path.push_front(4'(s));
        plan_cost = 0;
        plan_ok = 1;
        cost_leg(n, s, p);
        cost_leg(n, p, q);
        cost_leg(n, q, d);
    endtask

    // update the shadow state and queue the results an accepted item causes
    task automatic predict_item(input road_req_t rq);
        int          n;
        logic [3:0]  a_path [$];
        int unsigned a_cost;
        bit          a_ok;
        route_step_t st;
        case (rq.act)
            tws_pkg::ACT_CLEAR: begin
                foreach (road_tbl[i, k]) road_tbl[i][k] = '0;
            end
            tws_pkg::ACT_ADD: begin
                // first weight for a pair wins
                if (!road_tbl[rq.a][rq.b][16]) begin
                    road_tbl[rq.a][rq.b] = {1'b1, rq.w};
                    road_tbl[rq.b][rq.a] = {1'b1, rq.w};
                end
            end
            tws_pkg::ACT_FIND: begin
                n = active_nodes();
                if (rq.s >= n || rq.d >= n || rq.x >= n || rq.y >= n) begin
                    st = '{node: rq.s, cost: '0, unr: 1'b1, last: 1'b1};
                    route_expect.insert(route_expect.size(), st);
                end else begin
                    plan_order(n, rq.s, rq.x, rq.y, rq.d);
                    a_path = plan_path;
                    a_cost = plan_cost;
                    a_ok = plan_ok;
                    plan_order(n, rq.s, rq.y, rq.x, rq.d);
                    // second ordering wins unless the first is clean and strictly better
                    if (a_ok && (!plan_ok || a_cost < plan_cost)) begin
                        plan_path = a_path;
                        plan_cost = a_cost;
                        plan_ok = 1;
                    end
                    if (!plan_ok) plan_cost = 0;
                    foreach (plan_path[i]) begin
                        st.node = plan_path[i];
                        st.cost = plan_cost[21:0];
                        st.unr  = !plan_ok;
                        st.last = (i == plan_path.size() - 1);
                        route_expect.insert(route_expect.size(), st);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // drive one item and wait for it to be taken; valid stays up across back-to-back items
    task automatic send_item(input road_req_t rq, input bit typed, input route_step_t res);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.act;
        s_tdata  <= {rq.y, rq.x, rq.d, rq.s, rq.w, rq.b, rq.a};
        do @(posedge aclk); while (!s_tready);
        if (typed) route_expect.insert(route_expect.size(), res);
        else predict_item(rq);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (route_expect.size() != 0) @(posedge aclk);
        // an add or clear may still be in flight
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [4:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        node_cfg = v;
    endtask

    function automatic logic [3:0] pick_node(input int n);
        // mostly inside the active range, sometimes anywhere
        if ($urandom_range(99) < 8) return 4'($urandom_range(15));
        return 4'($urandom_range(n - 1));
    endfunction

    // one map: optional clear, a batch of roads, then a few route queries
    task automatic random_map(inout int cnt);
        int          n;
        road_req_t   rq;
        route_step_t none;
        none = '{default: '0};
        n = active_nodes();
        if ($urandom_range(99) < 30) begin
            rq = '{act: tws_pkg::ACT_CLEAR, a: 4'($urandom), b: 4'($urandom),
                   w: 16'($urandom), s: 4'($urandom), d: 4'($urandom), x: 4'($urandom),
                   y: 4'($urandom)};
            send_item(rq, 0, none);
            cnt++;
        end
        repeat ($urandom_range(0, 2 * n)) begin
            rq.act = tws_pkg::ACT_ADD;
            rq.a = pick_node(n);
            rq.b = pick_node(n);
            case ($urandom_range(4))
                0:       rq.w = 16'hFFFF;
                1:       rq.w = 16'($urandom_range(3));
                default: rq.w = 16'($urandom);
            endcase
            {rq.s, rq.d, rq.x, rq.y} = 16'($urandom);
            send_item(rq, 0, none);
            cnt++;
            // noise the block just ignores
            if ($urandom_range(99) < 5) begin
                rq.act = tws_pkg::ACT_NONE;
                send_item(rq, 0, none);
            end
        end
        repeat ($urandom_range(1, 3)) begin
            rq.act = tws_pkg::ACT_FIND;
            {rq.a, rq.b, rq.w} = 24'($urandom);
            rq.s = pick_node(n);
            rq.d = pick_node(n);
            rq.x = pick_node(n);
            rq.y = pick_node(n);
            send_item(rq, 0, none);
            cnt++;
        end
    endtask

    // result side: compare every accepted item with the oldest expectation
    always @(posedge aclk) begin
        route_step_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (route_expect.size() == 0) begin
                $display("%0t: unexpected result node=%0d cost=%0d unr=%0b last=%0b", $time,
                         m_tdata[3:0], m_tdata[25:4], m_tuser, m_tlast);
                failed = 1;
            end else begin
                e = route_expect.pop_front();
                if (m_tdata[3:0] !== e.node) begin
                    $display("%0t: route_node expected %0d actual %0d", $time, e.node,
                             m_tdata[3:0]);
                    failed = 1;
                end
                if (m_tdata[25:4] !== e.cost) begin
                    $display("%0t: total_cost expected %0d actual %0d", $time, e.cost,
                             m_tdata[25:4]);
                    failed = 1;
                end
                if (m_tuser !== e.unr) begin
                    $display("%0t: unreachable expected %0b actual %0b", $time, e.unr, m_tuser);
                    failed = 1;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last_node expected %0b actual %0b", $time, e.last, m_tlast);
                    failed = 1;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("two_waypoint_shortest_route verification failed");
            $finish;
        end
    end

    directed_row_t dir_rows [$];

    function automatic directed_row_t row(input tws_pkg::action_t act, input int a,
                                          input int b, input int w, input int s, input int d,
                                          input int x, input int y, input bit typed = 0,
                                          input int node = 0, input int unr = 0);
        directed_row_t r;
        r.req = '{act: act, a: 4'(a), b: 4'(b), w: 16'(w), s: 4'(s), d: 4'(d), x: 4'(x),
                  y: 4'(y)};
        r.typed = typed;
        r.res = '{node: 4'(node), cost: '0, unr: 1'(unr), last: 1'b1};
        return r;
    endfunction

    initial begin
        int            cnt;
        logic [4:0]    cfg_vals [6];
        int            src_pcts [6];
        int            snk_pcts [6];
        directed_row_t one_row;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        node_cfg = 5'd16;
        foreach (road_tbl[i, k]) road_tbl[i][k] = '0;
        cfg_vals = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd9};
        src_pcts = '{0, 48, 0, 29, 48, 0};
        snk_pcts = '{0, 0, 48, 29, 48, 29};

        // directed rows: empty table, repeated and self roads, extremes, clear
        dir_rows.push_front(row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)); // legs to self
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1));   // no roads
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_ADD, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_ADD, 1, 0, 5, 0, 0, 0, 0));             // repeated pair
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_ADD, 1, 2, 65535, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_ADD, 2, 15, 65535, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_ADD, 15, 15, 7, 0, 0, 0, 0));           // self road
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_ADD, 0, 3, 2, 15, 15, 15, 15));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_ADD, 3, 2, 65533, 0, 0, 0, 0));         // equal-cost tie
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_NONE, 15, 15, 65535, 15, 15, 15, 15));  // ignored
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 15, 1, 2));
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_FIND, 15, 15, 65535, 15, 0, 2, 1));
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 15, 3, 3));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_FIND, 0, 0, 0, 1, 1, 15, 4));           // unreachable leg
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_FIND, 0, 0, 0, 15, 0, 15, 15));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_CLEAR, 15, 15, 65535, 15, 15, 15, 15));
        dir_rows.insert(dir_rows.size(),
                        row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1));   // table emptied
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_ADD, 14, 15, 1, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(tws_pkg::ACT_FIND, 0, 0, 0, 14, 15, 15, 14));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        drain_and_settle();

        // node_count 2 makes most indexes out of range
        write_node_count(5'd2);
        one_row = row(tws_pkg::ACT_FIND, 0, 0, 0, 15, 0, 0, 1, 1, 15, 1);
        send_item(one_row.req, one_row.typed, one_row.res);
        one_row = row(tws_pkg::ACT_FIND, 0, 0, 0, 0, 1, 1, 0);
        send_item(one_row.req, one_row.typed, one_row.res);
        drain_and_settle();

        // random phases, each with its own node_count and idling mix
        for (int p = 0; p < 6; p++) begin
            write_node_count(cfg_vals[p]);
            src_idle_pct = src_pcts[p];
            snk_idle_pct = snk_pcts[p];
            cnt = 0;
            while (cnt < 60) random_map(cnt);
            drain_and_settle();
        end

        while (route_expect.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("two_waypoint_shortest_route verification clean");
        end else begin
            $display("two_waypoint_shortest_route verification failed");
        end
        $finish;
    end

endmodule
